// ===== src/dlpm_pkg.sv =====
// shared types and constants of the dfa longest prefix matcher
package dlpm_pkg;

    // field widths
    localparam int STATE_BITS = 8;
    localparam int CHAR_BITS  = 8;
    localparam int POS_BITS   = 16;

    // transition memory: one entry per (state, byte)
    localparam int TRANS_ADDR_BITS = STATE_BITS + CHAR_BITS;
    localparam int TRANS_DEPTH     = 1 << TRANS_ADDR_BITS;
    localparam int TRANS_BITS      = STATE_BITS + 1;
    localparam int ACC_DEPTH       = 1 << STATE_BITS;

    // result queue
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = FIFO_PTR_BITS + 1;

    // packed stream widths
    localparam int IN_DATA_BITS  = 48;
    localparam int IN_USER_BITS  = 2;
    localparam int OUT_DATA_BITS = 24;

    typedef enum logic [1:0] {
        ACT_WR_TRANS  = 2'd0,
        ACT_WR_ACCEPT = 2'd1,
        ACT_BEGIN     = 2'd2,
        ACT_CHAR      = 2'd3
    } t_action;

    typedef struct packed {
        t_action                action;
        logic [STATE_BITS-1:0]  table_state;
        logic [CHAR_BITS-1:0]   char_code;
        logic [STATE_BITS-1:0]  next_state;
        logic                   next_dead;
        logic                   accepting;
        logic [POS_BITS-1:0]    start_position;
        logic                   is_last;
    } t_item;

    typedef struct packed {
        logic                matched;
        logic [POS_BITS-1:0] match_end;
    } t_result;

    // status from the match core toward the input handshake
    typedef struct packed {
        logic       hold;       // a begin or char word still updates the state
        logic [1:0] last_cnt;   // results still inside the pipeline
    } t_core_status;

endpackage

// ===== src/dlpm_result_fifo.sv =====
// small result queue between the match pipeline and the output stream
module dlpm_result_fifo (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    input  dlpm_pkg::t_result                  i_push_data,
    input  logic                               i_pop,
    output logic                               o_not_empty,
    output dlpm_pkg::t_result                  o_head,
    output logic [dlpm_pkg::FIFO_CNT_BITS-1:0] o_count
);

    dlpm_pkg::t_result                  r_mem [0:dlpm_pkg::FIFO_DEPTH-1];
    logic [dlpm_pkg::FIFO_PTR_BITS-1:0] r_wr_ptr;
    logic [dlpm_pkg::FIFO_PTR_BITS-1:0] r_rd_ptr;
    logic [dlpm_pkg::FIFO_CNT_BITS-1:0] r_count;
    logic [dlpm_pkg::FIFO_PTR_BITS-1:0] n_wr_ptr;
    logic [dlpm_pkg::FIFO_PTR_BITS-1:0] n_rd_ptr;
    logic [dlpm_pkg::FIFO_CNT_BITS-1:0] n_count;
    logic                               w_pop;

    assign w_pop = i_pop && (r_count != '0);

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        case ({i_push, w_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_not_empty = (r_count != '0);
    assign o_head      = r_mem[r_rd_ptr];
    assign o_count     = r_count;

endmodule

// ===== src/dlpm_match_core.sv =====
// table memories and the three-stage lookup and update pipeline
module dlpm_match_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  dlpm_pkg::t_item                   i_item,
    input  logic [dlpm_pkg::STATE_BITS-1:0]   i_start_state,
    output dlpm_pkg::t_core_status            o_status,
    output logic                              o_res_valid,
    output dlpm_pkg::t_result                 o_res
);

    // tables
    logic [dlpm_pkg::TRANS_BITS-1:0] r_trans_mem [0:dlpm_pkg::TRANS_DEPTH-1];
    logic                            r_acc_mem   [0:dlpm_pkg::ACC_DEPTH-1];
    logic [dlpm_pkg::TRANS_BITS-1:0] r_trans_q;
    logic                            r_acc_q;

    // match state
    logic [dlpm_pkg::STATE_BITS-1:0] r_cur_state;
    logic                            r_stopped;
    logic [dlpm_pkg::POS_BITS-1:0]   r_position;
    logic [dlpm_pkg::POS_BITS-1:0]   r_best_end;
    logic                            r_found;
    logic [dlpm_pkg::STATE_BITS-1:0] n_cur_state;
    logic                            n_stopped;
    logic [dlpm_pkg::POS_BITS-1:0]   n_position;
    logic [dlpm_pkg::POS_BITS-1:0]   n_best_end;
    logic                            n_found;

    // lookup stage
    logic                            r_s2_vld;
    dlpm_pkg::t_action               r_s2_act;
    logic                            r_s2_last;
    logic [dlpm_pkg::POS_BITS-1:0]   r_s2_pos;

    // accept flag stage
    logic                            r_s3_vld;
    logic                            r_s3_last;
    logic                            r_s3_chk;
    logic                            r_s3_clr;
    logic [dlpm_pkg::POS_BITS-1:0]   r_s3_pos;
    logic                            n_s3_chk;
    logic                            n_s3_clr;
    logic [dlpm_pkg::POS_BITS-1:0]   n_s3_pos;
    logic [dlpm_pkg::STATE_BITS-1:0] w_acc_addr;

    logic                            w_wr_trans;
    logic                            w_wr_acc;
    logic                            w_dead;
    logic [dlpm_pkg::STATE_BITS-1:0] w_nxt;
    logic [dlpm_pkg::POS_BITS-1:0]   w_pos_inc;

    assign w_wr_trans = i_accept && (i_item.action == dlpm_pkg::ACT_WR_TRANS);
    assign w_wr_acc   = i_accept && (i_item.action == dlpm_pkg::ACT_WR_ACCEPT);

    // transition memory: table writes and char lookups both at acceptance
    always_ff @(posedge i_clk) begin
        if (w_wr_trans) begin
            r_trans_mem[{i_item.table_state, i_item.char_code}] <=
                {i_item.next_dead, i_item.next_state};
        end
        r_trans_q <= r_trans_mem[{r_cur_state, i_item.char_code}];
    end

    // accepting flag memory: write at acceptance, read one stage later
    always_ff @(posedge i_clk) begin
        if (w_wr_acc) begin
            r_acc_mem[i_item.table_state] <= i_item.accepting;
        end
        r_acc_q <= r_acc_mem[w_acc_addr];
    end

    // lookup stage: apply the transition or the begin
    assign w_dead    = r_trans_q[dlpm_pkg::TRANS_BITS-1];
    assign w_nxt     = r_trans_q[dlpm_pkg::STATE_BITS-1:0];
    assign w_pos_inc = (r_position == '1) ? r_position : r_position + 1'b1;

    always_comb begin
        n_cur_state = r_cur_state;
        n_stopped   = r_stopped;
        n_position  = r_position;
        n_s3_chk    = 1'b0;
        n_s3_clr    = 1'b0;
        n_s3_pos    = r_position;
        w_acc_addr  = w_nxt;
        if (r_s2_vld) begin
            case (r_s2_act)
                dlpm_pkg::ACT_BEGIN: begin
                    n_cur_state = i_start_state;
                    n_stopped   = 1'b0;
                    n_position  = r_s2_pos;
                    n_s3_clr    = 1'b1;
                    n_s3_pos    = r_s2_pos;
                    w_acc_addr  = i_start_state;
                end
                dlpm_pkg::ACT_CHAR: begin
                    if (!r_stopped) begin
                        if (w_dead) begin
                            n_stopped = 1'b1;
                        end else begin
                            n_cur_state = w_nxt;
                            n_position  = w_pos_inc;
                            n_s3_chk    = 1'b1;
                            n_s3_pos    = w_pos_inc;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // accept flag stage: record the end of the longest accepted prefix
    always_comb begin
        n_found    = r_found;
        n_best_end = r_best_end;
        if (r_s3_vld) begin
            if (r_s3_clr) begin
                n_found    = r_acc_q;
                n_best_end = r_acc_q ? r_s3_pos : '0;
            end else if (r_s3_chk && r_acc_q) begin
                n_found    = 1'b1;
                n_best_end = r_s3_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld    <= 1'b0;
            r_s3_vld    <= 1'b0;
            r_cur_state <= '0;
            r_stopped   <= 1'b0;
            r_position  <= '0;
            r_best_end  <= '0;
            r_found     <= 1'b0;
        end else begin
            r_s2_vld    <= i_accept;
            r_s3_vld    <= r_s2_vld;
            r_cur_state <= n_cur_state;
            r_stopped   <= n_stopped;
            r_position  <= n_position;
            r_best_end  <= n_best_end;
            r_found     <= n_found;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        r_s2_act  <= i_item.action;
        r_s2_last <= i_item.is_last;
        r_s2_pos  <= i_item.start_position;
        r_s3_last <= r_s2_last;
        r_s3_chk  <= n_s3_chk;
        r_s3_clr  <= n_s3_clr;
        r_s3_pos  <= n_s3_pos;
    end

    // status and result
    assign o_status.hold = r_s2_vld &&
        ((r_s2_act == dlpm_pkg::ACT_BEGIN) || (r_s2_act == dlpm_pkg::ACT_CHAR));
    assign o_status.last_cnt = {1'b0, r_s2_vld && r_s2_last} +
                               {1'b0, r_s3_vld && r_s3_last};

    assign o_res_valid     = r_s3_vld && r_s3_last;
    assign o_res.matched   = n_found;
    assign o_res.match_end = n_found ? n_best_end : '0;

endmodule

// ===== src/dfa_longest_prefix_matcher.sv =====
// top level of the dfa longest prefix matcher: stream ports and start state register
//
//  channel   direction  handshake              payload
//  s         in         i_s_tvalid/o_s_tready  tuser action, tdata table fields, tlast
//  m         out        o_m_tvalid/i_m_tready  tdata matched, match_end
//  cfg       in         i_cfg_valid/o_cfg_ready start_state
//
//  begin and char words cannot be taken back to back: the transition memory read must
//  return and update the current state before the next lookup address exists.
//  table write words are taken every cycle unless the input is stalled. a result
//  passes the lookup and accept flag stages into the 4-entry queue and waits there.
//  reset clears match state, queue and start state; both tables hold garbage until written.
//  input stalls while the queue could not take every result still in flight.
module dfa_longest_prefix_matcher (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // table_state[7:0], char_code[15:8], next_state[23:16], next_dead[24],
    // accepting[25], start_position[41:26], zero fill
    input  logic [dlpm_pkg::IN_DATA_BITS-1:0]  i_s_tdata,
    // action[1:0]
    input  logic [dlpm_pkg::IN_USER_BITS-1:0]  i_s_tuser,
    input  logic                               i_s_tlast,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // matched[0], match_end[16:1], zero fill
    output logic [dlpm_pkg::OUT_DATA_BITS-1:0] o_m_tdata,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [dlpm_pkg::STATE_BITS-1:0]    i_cfg_data
);

    logic [dlpm_pkg::STATE_BITS-1:0]    r_start_state;
    dlpm_pkg::t_item                    w_item;
    dlpm_pkg::t_core_status             w_status;
    dlpm_pkg::t_result                  w_res;
    dlpm_pkg::t_result                  w_head;
    logic                               w_res_valid;
    logic                               w_accept;
    logic [dlpm_pkg::FIFO_CNT_BITS-1:0] w_fifo_cnt;
    logic [dlpm_pkg::FIFO_CNT_BITS-1:0] w_pending;

    // start state register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_state <= '0;
        end else if (i_cfg_valid) begin
            r_start_state <= i_cfg_data;
        end
    end

    // unpack the input word
    assign w_item.action         = dlpm_pkg::t_action'(i_s_tuser);
    assign w_item.table_state    = i_s_tdata[7:0];
    assign w_item.char_code      = i_s_tdata[15:8];
    assign w_item.next_state     = i_s_tdata[23:16];
    assign w_item.next_dead      = i_s_tdata[24];
    assign w_item.accepting      = i_s_tdata[25];
    assign w_item.start_position = i_s_tdata[41:26];
    assign w_item.is_last        = i_s_tlast;

    // input ready: state settled and room for every result in flight
    assign w_pending  = w_fifo_cnt + {1'b0, w_status.last_cnt};
    assign o_s_tready = !w_status.hold &&
                        (w_pending < dlpm_pkg::FIFO_CNT_BITS'(dlpm_pkg::FIFO_DEPTH));
    assign w_accept   = i_s_tvalid && o_s_tready;

    dlpm_match_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_item        (w_item),
        .i_start_state (r_start_state),
        .o_status      (w_status),
        .o_res_valid   (w_res_valid),
        .o_res         (w_res)
    );

    dlpm_result_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_res_valid),
        .i_push_data (w_res),
        .i_pop       (i_m_tready),
        .o_not_empty (o_m_tvalid),
        .o_head      (w_head),
        .o_count     (w_fifo_cnt)
    );

    // pack the output word
    assign o_m_tdata = {7'd0, w_head.match_end, w_head.matched};

endmodule
